>>> rtl/imusbc_pkg.sv
// ----------------------------------------------------------------------------
// imusbc_pkg
// Shared types, codes and constants for the IMU still-bias calibrator.
// ----------------------------------------------------------------------------
package imusbc_pkg;

   // Default module parameters
   localparam int ZERO_SAMPLES_DEF = 64;
   localparam int SAMPLE_BITS_DEF  = 16;

   // Fixed field widths
   localparam int CFG_W     = 15;
   localparam int SQ_W      = 2 * CFG_W;
   localparam int STREAK_W  = 8;
   localparam int TEMP_W    = 16;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};

   // Register reset values
   localparam logic [CFG_W-1:0]    MIN_NORM_RST    = CFG_W'(512);
   localparam logic [CFG_W-1:0]    MAX_NORM_RST    = CFG_W'(7680);
   localparam logic [CFG_W-1:0]    GYRO_LIMIT_RST  = CFG_W'(96);
   localparam logic [CFG_W-1:0]    ACCEL_DRIFT_RST = CFG_W'(128);
   localparam logic [STREAK_W-1:0] FAIL_LIMIT_RST  = STREAK_W'(5);

   // Operation codes of an input item
   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_ZERO   = 2'd1,
      OP_ONLINE = 2'd2
   } op_type;

   // Sensor status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OFFLINE  = 2'd0,
      ST_INIT     = 2'd1,
      ST_HEALTHY  = 2'd2,
      ST_DEGRADED = 2'd3
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_NORM    = 3'd0,
      CSR_MAX_NORM    = 3'd1,
      CSR_GYRO_LIMIT  = 3'd2,
      CSR_ACCEL_DRIFT = 3'd3,
      CSR_FAIL_LIMIT  = 3'd4
   } csr_idx_type;

   // Limits as seen by the datapath (squares already formed)
   typedef struct packed {
      logic [SQ_W-1:0]     min_norm_sq;
      logic [SQ_W-1:0]     max_norm_sq;
      logic [CFG_W-1:0]    gyro_limit;
      logic [SQ_W-1:0]     drift_sq;
      logic [STREAK_W-1:0] fail_limit;
   } limits_type;

   // Control part of a captured item
   typedef struct packed {
      op_type op;
      logic   sample_ok;
   } item_ctrl_type;

endpackage

>>> rtl/imusbc_core.sv
// Flow: an accepted item passes the input register, then the result register,
// before its result is shown.
// Throughput: one item per cycle unless the result stalls; the state loop
// closes through the calculation stage: consecutive items need no bubble.
// Reset: synchronous, active high; clears the sensor and calibration state and
// loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// imusbc_core
// IMU still-bias calibrator: validates samples, averages biases while the
// sensor is still and returns bias-corrected readings with a status.
// ----------------------------------------------------------------------------
module imu_still_bias_calibrator_core #(
   parameter int ZERO_SAMPLES = imusbc_pkg::ZERO_SAMPLES_DEF,
   parameter int SAMPLE_BITS  = imusbc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [imusbc_pkg::OP_W-1:0]          req_operation,
   input  logic                                 req_read_ok,
   input  logic signed [SAMPLE_BITS-1:0]        req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]        req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]        req_accel_z,
   input  logic signed [SAMPLE_BITS-1:0]        req_rate_x,
   input  logic signed [SAMPLE_BITS-1:0]        req_rate_y,
   input  logic signed [SAMPLE_BITS-1:0]        req_rate_z,
   input  logic signed [imusbc_pkg::TEMP_W-1:0] req_temp_in,
   // Result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [imusbc_pkg::STATUS_W-1:0]      rsp_status,
   output logic                                 rsp_is_calibrated,
   output logic                                 rsp_is_zeroing,
   output logic                                 rsp_request_accepted,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_accel_x,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_accel_y,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_accel_z,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_rate_x,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_rate_y,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_rate_z,
   output logic signed [imusbc_pkg::TEMP_W-1:0] rsp_temp_out,
   // Configuration
   input  logic                                 csr_write_enable,
   input  logic [imusbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [imusbc_pkg::CFG_W-1:0]         csr_write_data
);

   imusbc_pkg::limits_type               limits;
   imusbc_pkg::item_ctrl_type            s0_ctrl;
   imusbc_pkg::status_type               status;
   logic                                 s0_valid;
   logic                                 accept;
   logic                                 advance;
   logic                                 fire;
   logic signed [SAMPLE_BITS-1:0]        accel [3];
   logic signed [SAMPLE_BITS-1:0]        rate [3];
   logic signed [SAMPLE_BITS-1:0]        s0_accel [3];
   logic signed [SAMPLE_BITS-1:0]        s0_rate [3];
   logic signed [imusbc_pkg::TEMP_W-1:0] s0_temp;
   logic signed [SAMPLE_BITS:0]          corr_accel [3];
   logic signed [SAMPLE_BITS:0]          corr_rate [3];

   // Gather the axes
   assign accel[0] = req_accel_x;
   assign accel[1] = req_accel_y;
   assign accel[2] = req_accel_z;
   assign rate[0]  = req_rate_x;
   assign rate[1]  = req_rate_y;
   assign rate[2]  = req_rate_z;

   // Handshake: the result register frees up when empty or taken
   assign advance   = ~rsp_valid | ~rsp_stall;
   assign fire      = s0_valid & advance;
   assign req_stall = s0_valid & ~advance;
   assign accept    = req_valid & ~req_stall;

   imusbc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .limits           (limits)
   );

   imusbc_in_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .operation (req_operation),
      .read_ok   (req_read_ok),
      .accel     (accel),
      .rate      (rate),
      .temp_in   (req_temp_in),
      .limits    (limits),
      .s0_valid  (s0_valid),
      .s0_ctrl   (s0_ctrl),
      .s0_accel  (s0_accel),
      .s0_rate   (s0_rate),
      .s0_temp   (s0_temp)
   );

   imusbc_calc #(
      .ZERO_SAMPLES (ZERO_SAMPLES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_calc (
      .clock                (clock),
      .reset                (reset),
      .fire                 (fire),
      .rsp_stall            (rsp_stall),
      .limits               (limits),
      .s0_ctrl              (s0_ctrl),
      .s0_accel             (s0_accel),
      .s0_rate              (s0_rate),
      .s0_temp              (s0_temp),
      .rsp_valid            (rsp_valid),
      .rsp_status           (status),
      .rsp_is_calibrated    (rsp_is_calibrated),
      .rsp_is_zeroing       (rsp_is_zeroing),
      .rsp_request_accepted (rsp_request_accepted),
      .rsp_corr_accel       (corr_accel),
      .rsp_corr_rate        (corr_rate),
      .rsp_temp_out         (rsp_temp_out)
   );

   // Spread the result axes
   assign rsp_status       = status;
   assign rsp_corr_accel_x = corr_accel[0];
   assign rsp_corr_accel_y = corr_accel[1];
   assign rsp_corr_accel_z = corr_accel[2];
   assign rsp_corr_rate_x  = corr_rate[0];
   assign rsp_corr_rate_y  = corr_rate[1];
   assign rsp_corr_rate_z  = corr_rate[2];

endmodule

>>> rtl/imusbc_csr.sv
// ----------------------------------------------------------------------------
// imusbc_csr
// Configuration registers and the squared limits derived from them.
// ----------------------------------------------------------------------------
module imusbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [imusbc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [imusbc_pkg::CFG_W-1:0]        csr_write_data,
   output imusbc_pkg::limits_type              limits
);

   logic [imusbc_pkg::CFG_W-1:0]    min_norm_ff, min_norm_in;
   logic [imusbc_pkg::CFG_W-1:0]    max_norm_ff, max_norm_in;
   logic [imusbc_pkg::CFG_W-1:0]    gyro_limit_ff, gyro_limit_in;
   logic [imusbc_pkg::CFG_W-1:0]    accel_drift_ff, accel_drift_in;
   logic [imusbc_pkg::STREAK_W-1:0] fail_limit_ff, fail_limit_in;

   // Decode the register write
   always_comb begin
      min_norm_in    = min_norm_ff;
      max_norm_in    = max_norm_ff;
      gyro_limit_in  = gyro_limit_ff;
      accel_drift_in = accel_drift_ff;
      fail_limit_in  = fail_limit_ff;
      if (csr_write_enable) begin
         case (imusbc_pkg::csr_idx_type'(csr_index))
            imusbc_pkg::CSR_MIN_NORM:    min_norm_in    = csr_write_data;
            imusbc_pkg::CSR_MAX_NORM:    max_norm_in    = csr_write_data;
            imusbc_pkg::CSR_GYRO_LIMIT:  gyro_limit_in  = csr_write_data;
            imusbc_pkg::CSR_ACCEL_DRIFT: accel_drift_in = csr_write_data;
            imusbc_pkg::CSR_FAIL_LIMIT:
               fail_limit_in = csr_write_data[imusbc_pkg::STREAK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff    <= imusbc_pkg::MIN_NORM_RST;
         max_norm_ff    <= imusbc_pkg::MAX_NORM_RST;
         gyro_limit_ff  <= imusbc_pkg::GYRO_LIMIT_RST;
         accel_drift_ff <= imusbc_pkg::ACCEL_DRIFT_RST;
         fail_limit_ff  <= imusbc_pkg::FAIL_LIMIT_RST;
      end else begin
         min_norm_ff    <= min_norm_in;
         max_norm_ff    <= max_norm_in;
         gyro_limit_ff  <= gyro_limit_in;
         accel_drift_ff <= accel_drift_in;
         fail_limit_ff  <= fail_limit_in;
      end
   end

   // Square the distance limits
   always_comb begin
      limits.min_norm_sq = imusbc_pkg::SQ_W'(min_norm_ff) * imusbc_pkg::SQ_W'(min_norm_ff);
      limits.max_norm_sq = imusbc_pkg::SQ_W'(max_norm_ff) * imusbc_pkg::SQ_W'(max_norm_ff);
      limits.drift_sq    = imusbc_pkg::SQ_W'(accel_drift_ff)
                         * imusbc_pkg::SQ_W'(accel_drift_ff);
      limits.gyro_limit  = gyro_limit_ff;
      limits.fail_limit  = fail_limit_ff;
   end

endmodule

>>> rtl/imusbc_in_stage.sv
// ----------------------------------------------------------------------------
// imusbc_in_stage
// Input register: captures an item and its acceleration norm check.
// ----------------------------------------------------------------------------
module imusbc_in_stage #(
   parameter int SAMPLE_BITS = imusbc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 advance,
   input  logic [imusbc_pkg::OP_W-1:0]          operation,
   input  logic                                 read_ok,
   input  logic signed [SAMPLE_BITS-1:0]        accel [3],
   input  logic signed [SAMPLE_BITS-1:0]        rate [3],
   input  logic signed [imusbc_pkg::TEMP_W-1:0] temp_in,
   input  imusbc_pkg::limits_type               limits,
   output logic                                 s0_valid,
   output imusbc_pkg::item_ctrl_type            s0_ctrl,
   output logic signed [SAMPLE_BITS-1:0]        s0_accel [3],
   output logic signed [SAMPLE_BITS-1:0]        s0_rate [3],
   output logic signed [imusbc_pkg::TEMP_W-1:0] s0_temp
);

   localparam int SQR_W  = 2 * SAMPLE_BITS;
   localparam int NORM_W = (SQR_W > imusbc_pkg::SQ_W) ? SQR_W : imusbc_pkg::SQ_W;

   logic                                 valid_ff, valid_in;
   imusbc_pkg::item_ctrl_type            ctrl_ff, ctrl_in;
   logic signed [SAMPLE_BITS-1:0]        accel_ff [3];
   logic signed [SAMPLE_BITS-1:0]        rate_ff [3];
   logic signed [imusbc_pkg::TEMP_W-1:0] temp_ff;
   logic signed [SQR_W-1:0]              accel_wide [3];
   logic [SQR_W-1:0]                     accel_sq [3];
   logic [NORM_W-1:0]                    norm_sq;

   // Square and sum the acceleration axes
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         accel_wide[i] = {{SAMPLE_BITS{accel[i][SAMPLE_BITS-1]}}, accel[i]};
         accel_sq[i]   = $unsigned(accel_wide[i] * accel_wide[i]);
      end
      norm_sq = NORM_W'(accel_sq[0]) + NORM_W'(accel_sq[1]) + NORM_W'(accel_sq[2]);
   end

   // Build the control word of the incoming item
   always_comb begin
      ctrl_in.op        = imusbc_pkg::op_type'(operation);
      ctrl_in.sample_ok = read_ok
                        && (norm_sq >= NORM_W'(limits.min_norm_sq))
                        && (norm_sq <= NORM_W'(limits.max_norm_sq));
      valid_in = accept | (valid_ff & ~advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the item moves on
   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff  <= ctrl_in;
         accel_ff <= accel;
         rate_ff  <= rate;
         temp_ff  <= temp_in;
      end
   end

   assign s0_valid = valid_ff;
   assign s0_ctrl  = ctrl_ff;
   assign s0_accel = accel_ff;
   assign s0_rate  = rate_ff;
   assign s0_temp  = temp_ff;

endmodule

>>> rtl/imusbc_calc.sv
// ----------------------------------------------------------------------------
// imusbc_calc
// Calibration state, stillness checks, bias averaging and result register.
// ----------------------------------------------------------------------------
module imusbc_calc #(
   parameter int ZERO_SAMPLES = imusbc_pkg::ZERO_SAMPLES_DEF,
   parameter int SAMPLE_BITS  = imusbc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 fire,
   input  logic                                 rsp_stall,
   input  imusbc_pkg::limits_type               limits,
   input  imusbc_pkg::item_ctrl_type            s0_ctrl,
   input  logic signed [SAMPLE_BITS-1:0]        s0_accel [3],
   input  logic signed [SAMPLE_BITS-1:0]        s0_rate [3],
   input  logic signed [imusbc_pkg::TEMP_W-1:0] s0_temp,
   output logic                                 rsp_valid,
   output imusbc_pkg::status_type               rsp_status,
   output logic                                 rsp_is_calibrated,
   output logic                                 rsp_is_zeroing,
   output logic                                 rsp_request_accepted,
   output logic signed [SAMPLE_BITS:0]          rsp_corr_accel [3],
   output logic signed [SAMPLE_BITS:0]          rsp_corr_rate [3],
   output logic signed [imusbc_pkg::TEMP_W-1:0] rsp_temp_out
);

   localparam int B      = SAMPLE_BITS;
   localparam int CNT_W  = $clog2(ZERO_SAMPLES + 1);
   localparam int LOGN   = $clog2(ZERO_SAMPLES);
   localparam int SUM_W  = B + LOGN;
   localparam int MAG_W  = (B + 1 > imusbc_pkg::CFG_W) ? B + 1 : imusbc_pkg::CFG_W;
   localparam int DSQ_W  = 2 * B + 2;
   localparam int D2_W   = DSQ_W + 2;
   localparam int CMP_W  = (D2_W > imusbc_pkg::SQ_W) ? D2_W : imusbc_pkg::SQ_W;
   // Floor division by the sample count through a reciprocal multiply
   localparam int K       = SUM_W + LOGN;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << K) + longint'(ZERO_SAMPLES) - 64'd1) / longint'(ZERO_SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam longint unsigned OFFSET_VAL = longint'(ZERO_SAMPLES) << (B - 1);
   localparam logic [SUM_W-1:0] OFFSET = SUM_W'(OFFSET_VAL);
   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(ZERO_SAMPLES - 1);

   // Calibration state
   logic                                 online_ff, online_in;
   logic                                 has_sample_ff, has_sample_in;
   logic                                 calibrated_ff, calibrated_in;
   logic                                 zeroing_ff, zeroing_in;
   logic [imusbc_pkg::STREAK_W-1:0]      streak_ff, streak_in;
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic signed [B-1:0]                  ref_ff [3], ref_in [3];
   logic signed [SUM_W-1:0]              acc_sum_ff [3], acc_sum_in [3];
   logic signed [SUM_W-1:0]              rate_sum_ff [3], rate_sum_in [3];
   logic signed [B-1:0]                  acc_bias_ff [3], acc_bias_in [3];
   logic signed [B-1:0]                  rate_bias_ff [3], rate_bias_in [3];
   logic signed [imusbc_pkg::TEMP_W-1:0] temp_ff, temp_in;

   // Result register
   logic                                 rsp_valid_ff, rsp_valid_in;
   imusbc_pkg::status_type               status_ff, status_in;
   logic                                 accepted_ff, accepted_in;
   logic signed [B:0]                    corr_acc_ff [3], corr_acc_in [3];
   logic signed [B:0]                    corr_rate_ff [3], corr_rate_in [3];
   logic                                 cal_out_ff, zero_out_ff;
   logic signed [imusbc_pkg::TEMP_W-1:0] temp_out_ff;

   // Datapath terms
   logic [MAG_W-1:0]        gyro_mag [3];
   logic                    gyro_moving;
   logic signed [B:0]       drift [3];
   logic signed [DSQ_W-1:0] drift_wide [3];
   logic [DSQ_W-1:0]        drift_sq [3];
   logic [CMP_W-1:0]        drift_total;
   logic                    drift_over;
   logic signed [SUM_W-1:0] acc_sum_plus [3];
   logic signed [SUM_W-1:0] rate_sum_plus [3];
   logic signed [B-1:0]     acc_bias_new [3];
   logic signed [B-1:0]     rate_bias_new [3];
   logic                    corr_en;

   function automatic logic signed [B-1:0] floor_avg(input logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0]  u;
      logic [PROD_W-1:0] p;
      logic [B-1:0]      q;
      u = $unsigned(s) + OFFSET;
      p = PROD_W'(u) * PROD_W'(RECIP);
      q = p[K+B-1:K];
      return $signed({~q[B-1], q[B-2:0]});
   endfunction

   // Stillness checks and candidate sums and biases
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gyro_mag[i] = s0_rate[i][B-1] ? MAG_W'(-(B+1)'(s0_rate[i]))
                                       : MAG_W'($unsigned(s0_rate[i]));
         drift[i]      = (B+1)'(s0_accel[i]) - (B+1)'(ref_ff[i]);
         drift_wide[i] = DSQ_W'(drift[i]);
         drift_sq[i]   = $unsigned(drift_wide[i] * drift_wide[i]);
         acc_sum_plus[i]  = acc_sum_ff[i] + {{LOGN{s0_accel[i][B-1]}}, s0_accel[i]};
         rate_sum_plus[i] = rate_sum_ff[i] + {{LOGN{s0_rate[i][B-1]}}, s0_rate[i]};
         acc_bias_new[i]  = floor_avg(acc_sum_plus[i]);
         rate_bias_new[i] = floor_avg(rate_sum_plus[i]);
      end
      gyro_moving = (gyro_mag[0] > MAG_W'(limits.gyro_limit))
                 || (gyro_mag[1] > MAG_W'(limits.gyro_limit))
                 || (gyro_mag[2] > MAG_W'(limits.gyro_limit));
      drift_total = CMP_W'(drift_sq[0]) + CMP_W'(drift_sq[1]) + CMP_W'(drift_sq[2]);
      drift_over  = drift_total > CMP_W'(limits.drift_sq);
   end

   // Next state for the item in the input register
   always_comb begin
      online_in     = online_ff;
      has_sample_in = has_sample_ff;
      calibrated_in = calibrated_ff;
      zeroing_in    = zeroing_ff;
      streak_in     = streak_ff;
      count_in      = count_ff;
      ref_in        = ref_ff;
      acc_sum_in    = acc_sum_ff;
      rate_sum_in   = rate_sum_ff;
      acc_bias_in   = acc_bias_ff;
      rate_bias_in  = rate_bias_ff;
      temp_in       = temp_ff;
      accepted_in   = 1'b0;
      corr_en       = 1'b0;

      case (s0_ctrl.op)
         imusbc_pkg::OP_SAMPLE: begin
            if (online_ff) begin
               if (s0_ctrl.sample_ok) begin
                  streak_in     = '0;
                  has_sample_in = 1'b1;
                  temp_in       = s0_temp;
                  if (zeroing_ff) begin
                     if (gyro_moving || (count_ff != '0 && drift_over)) begin
                        // restart averaging
                        count_in      = '0;
                        calibrated_in = 1'b0;
                        zeroing_in    = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                           ref_in[i]       = '0;
                           acc_sum_in[i]   = '0;
                           rate_sum_in[i]  = '0;
                           acc_bias_in[i]  = '0;
                           rate_bias_in[i] = '0;
                        end
                     end else begin
                        if (count_ff == '0) begin
                           ref_in = s0_accel;
                        end
                        acc_sum_in  = acc_sum_plus;
                        rate_sum_in = rate_sum_plus;
                        count_in    = count_ff + CNT_W'(1);
                        if (count_ff == LAST_COUNT) begin
                           acc_bias_in   = acc_bias_new;
                           rate_bias_in  = rate_bias_new;
                           calibrated_in = 1'b1;
                           zeroing_in    = 1'b0;
                        end
                     end
                  end
                  corr_en = calibrated_in;
               end else begin
                  // count the failure, saturating
                  if (streak_ff != imusbc_pkg::STREAK_MAX) begin
                     streak_in = streak_ff + imusbc_pkg::STREAK_W'(1);
                  end
                  if (streak_in >= limits.fail_limit) begin
                     online_in     = 1'b0;
                     has_sample_in = 1'b0;
                     calibrated_in = 1'b0;
                     zeroing_in    = 1'b0;
                  end
               end
            end
         end
         imusbc_pkg::OP_ZERO: begin
            if (online_ff && has_sample_ff) begin
               accepted_in   = 1'b1;
               count_in      = '0;
               calibrated_in = 1'b0;
               zeroing_in    = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  ref_in[i]       = '0;
                  acc_sum_in[i]   = '0;
                  rate_sum_in[i]  = '0;
                  acc_bias_in[i]  = '0;
                  rate_bias_in[i] = '0;
               end
            end
         end
         imusbc_pkg::OP_ONLINE: begin
            online_in     = 1'b1;
            has_sample_in = 1'b0;
            streak_in     = '0;
            count_in      = '0;
            calibrated_in = 1'b0;
            zeroing_in    = 1'b1;
            for (int i = 0; i < 3; i++) begin
               ref_in[i]       = '0;
               acc_sum_in[i]   = '0;
               rate_sum_in[i]  = '0;
               acc_bias_in[i]  = '0;
               rate_bias_in[i] = '0;
            end
         end
         default: ;
      endcase

      // Correct the sample with the biases in force after this item
      for (int i = 0; i < 3; i++) begin
         corr_acc_in[i]  = corr_en ? (B+1)'(s0_accel[i]) - (B+1)'(acc_bias_in[i]) : '0;
         corr_rate_in[i] = corr_en ? (B+1)'(s0_rate[i]) - (B+1)'(rate_bias_in[i]) : '0;
      end

      // Derive status from the updated state
      if (!online_in) begin
         status_in = imusbc_pkg::ST_OFFLINE;
      end else if (!has_sample_in || zeroing_in || !calibrated_in) begin
         status_in = imusbc_pkg::ST_INIT;
      end else if (streak_in != '0) begin
         status_in = imusbc_pkg::ST_DEGRADED;
      end else begin
         status_in = imusbc_pkg::ST_HEALTHY;
      end

      rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);
   end

   // Advance state on each processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff     <= 1'b0;
         has_sample_ff <= 1'b0;
         calibrated_ff <= 1'b0;
         zeroing_ff    <= 1'b0;
         streak_ff     <= '0;
         count_ff      <= '0;
         temp_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            ref_ff[i]       <= '0;
            acc_sum_ff[i]   <= '0;
            rate_sum_ff[i]  <= '0;
            acc_bias_ff[i]  <= '0;
            rate_bias_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            online_ff     <= online_in;
            has_sample_ff <= has_sample_in;
            calibrated_ff <= calibrated_in;
            zeroing_ff    <= zeroing_in;
            streak_ff     <= streak_in;
            count_ff      <= count_in;
            temp_ff       <= temp_in;
            ref_ff        <= ref_in;
            acc_sum_ff    <= acc_sum_in;
            rate_sum_ff   <= rate_sum_in;
            acc_bias_ff   <= acc_bias_in;
            rate_bias_ff  <= rate_bias_in;
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff    <= status_in;
         cal_out_ff   <= calibrated_in;
         zero_out_ff  <= zeroing_in;
         accepted_ff  <= accepted_in;
         corr_acc_ff  <= corr_acc_in;
         corr_rate_ff <= corr_rate_in;
         temp_out_ff  <= temp_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_is_calibrated    = cal_out_ff;
   assign rsp_is_zeroing       = zero_out_ff;
   assign rsp_request_accepted = accepted_ff;
   assign rsp_corr_accel       = corr_acc_ff;
   assign rsp_corr_rate        = corr_rate_ff;
   assign rsp_temp_out         = temp_out_ff;

`ifndef SYNTHESIS
   a_cal_zero_excl: assert property (@(posedge clock) disable iff (reset)
      !(calibrated_ff && zeroing_ff))
      else $error("calibrated and zeroing both set");

   a_offline_clear: assert property (@(posedge clock) disable iff (reset)
      !online_ff |-> (!has_sample_ff && !calibrated_ff && !zeroing_ff))
      else $error("offline sensor keeps sample or calibration state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(ZERO_SAMPLES)) && (zeroing_ff || !calibrated_ff
         || count_ff == CNT_W'(ZERO_SAMPLES)))
      else $error("still count out of range");

   a_accept_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && accepted_ff) |-> (zero_out_ff && !cal_out_ff
         && status_ff == imusbc_pkg::ST_INIT))
      else $error("accepted zero request did not restart averaging");
`endif

endmodule
